[hw/rtl/hair_cell_receptor_potential_assert.svh]
// Assertion macros shared by the receptor potential RTL.
`ifndef HAIR_CELL_RECEPTOR_POTENTIAL_ASSERT_SVH
`define HAIR_CELL_RECEPTOR_POTENTIAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define HCRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HCRP_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define HCRP_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HCRP_ASSERT(lbl, prop, msg)
`define HCRP_IMPLY(lbl, ante, cons, msg)
`define HCRP_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/hcrp_pkg.sv]
// Types, constants and helpers of the receptor potential block.
package hcrp_pkg;

	localparam int DELAY_MAX = 1024;
	localparam int DELAY_AW  = $clog2(DELAY_MAX);
	localparam int DIV_STEPS = 31;

	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [24:0] TANH_LIMIT  = 25'd655360;
	localparam logic [24:0] GAIN_CLAMP  = 25'h100_0000;
	localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

	typedef enum logic [2:0] {
		REG_INPUT_GAIN    = 3'd0,
		REG_NL_BIAS       = 3'd1,
		REG_NL_SCALE      = 3'd2,
		REG_LP_POLE       = 3'd3,
		REG_LP_ZERO_GAIN  = 3'd4,
		REG_DELAY_SAMPLES = 3'd5,
		REG_REF_OFFSET    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        [39:0] input_gain;
		logic signed [18:0] nl_bias;
		logic        [23:0] nl_scale;
		logic signed [31:0] lp_pole;
		logic signed [31:0] lp_zero_gain;
		logic        [10:0] delay_samples;
		logic signed [31:0] ref_offset;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [61:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GAIN_HI, ST_GAIN_LO, ST_GAIN_SUM,
		ST_T_START, ST_T_MUL, ST_T_DIV, ST_T_DWAIT, ST_T_SQ, ST_T_SQR,
		ST_T_QDIV, ST_T_QWAIT, ST_T_DONE,
		ST_NL_MUL, ST_NL_RND,
		ST_LP_M1, ST_LP_M2, ST_LP_M3, ST_LP_END,
		ST_RD, ST_WR, ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -66'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// ceil(2^30 / n); exact floor division for dividends below 2^27
	function automatic logic [30:0] recip_q30(input logic [2:0] n);
		logic [30:0] r;
		unique case (n)
			3'd2:    r = 31'd536870912;
			3'd3:    r = 31'd357913942;
			3'd4:    r = 31'd268435456;
			3'd5:    r = 31'd214748365;
			3'd6:    r = 31'd178956971;
			default: r = ONE_Q30;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/hair_cell_receptor_potential.sv]
// Receptor potential: gain, tanh nonlinearity, two lowpass sections, delay.
//
//  channel | signals                              | beat when
//  in      | in_valid, in_stall, bm_sample        | in_valid & !in_stall
//  out     | out_valid, out_stall, potential      | out_valid & !out_stall
//  cfg     | psel penable pwrite paddr pwdata ... | psel & penable & pwrite
//
// A new sample is accepted only once the last has gone through gain, then per
// tanh six series terms, eight squarings and the quotient, then nonlinearity,
// lowpass, delay and result; a tanh argument of ten or more skips its series.
// Reset needs no clearing pass: delay entries not yet written read as zero.
// A result waiting on out_stall holds the sequencer only at its last step.
`include "hair_cell_receptor_potential_assert.svh"
module hair_cell_receptor_potential import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] bm_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] potential,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	cfg_t   cfg;
	state_t state_q, state_d;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	div_req_t           div_req;
	logic               div_busy;
	logic [30:0]        div_quo;

	logic                ram_we;
	logic [DELAY_AW-1:0] rd_addr;
	logic [31:0]         ram_rdata;

	logic                x_neg_q;
	logic [31:0]         mag_q;
	logic signed [65:0]  acc_q;
	logic signed [25:0]  u_q;
	logic                sel_q, tneg_q, sec_q;
	logic [26:0]         w_q;
	logic [30:0]         term_q, e_q, tr_q;
	logic [2:0]          n_q, sq_q;
	logic signed [32:0]  s_q;
	logic signed [31:0]  wave_q, nl_prev_q, lp1_q, lp2_in_q, lp2_out_q;
	logic [DELAY_AW-1:0] ptr_q;
	logic                wrapped_q, rd_ok_q;
	logic signed [31:0]  res_q;
	logic                out_valid_q;
	logic [31:0]         potential_q;

	hcrp_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	hcrp_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p_q(mul_p));

	hcrp_div u_div (.clk, .arst_n, .req(div_req), .busy(div_busy), .quo(div_quo));

	hcrp_ram #(.WIDTH(32), .DEPTH(DELAY_MAX)) u_dly (
		.clk, .we(ram_we), .waddr(ptr_q), .wdata(lp2_out_q), .raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// gain and clamp
	logic signed [65:0] gain_sum;
	logic [53:0]        g_t;
	logic [24:0]        g_cl;
	logic signed [25:0] g_temp, u_d;
	assign gain_sum = acc_q + (mul_p >>> 20);
	assign g_t      = gain_sum[65:12];
	assign g_cl     = (g_t > 54'(GAIN_CLAMP)) ? GAIN_CLAMP : g_t[24:0];
	assign g_temp   = x_neg_q ? -$signed({1'b0, g_cl}) : $signed({1'b0, g_cl});
	assign u_d      = g_temp - 26'(cfg.nl_bias);

	// tanh argument
	logic signed [25:0] t_arg;
	logic [24:0]        t_abs;
	logic               t_big;
	logic signed [25:0] t_neg_arg;
	assign t_arg     = sel_q ? u_q : 26'(cfg.nl_bias);
	assign t_neg_arg = -t_arg;
	assign t_abs     = t_arg[25] ? t_neg_arg[24:0] : t_arg[24:0];
	assign t_big     = t_abs >= TANH_LIMIT;

	// series term divided by n through its reciprocal
	logic [30:0] rcp_quo;
	assign rcp_quo = {4'd0, mul_p[56:30]};

	logic [61:0]        sq_rnd;
	logic signed [32:0] tr_signed;
	assign sq_rnd    = mul_p[61:0] + 62'(HALF_Q30);
	assign tr_signed = tneg_q ? -$signed({2'b0, tr_q}) : $signed({2'b0, tr_q});

	logic signed [65:0] nl_rnd, lp_sum;
	logic signed [31:0] lp_y;
	assign nl_rnd = mul_p + HALF_Q30;
	assign lp_sum = acc_q + mul_p + HALF_Q30;
	assign lp_y   = sat32(lp_sum >>> 30);

	// delay read slot
	logic [DELAY_AW:0]   d_cl;
	logic signed [31:0]  rd_val;
	always_comb begin
		if (cfg.delay_samples == '0)
			d_cl = (DELAY_AW+1)'(1);
		else if (cfg.delay_samples > 11'(DELAY_MAX))
			d_cl = (DELAY_AW+1)'(DELAY_MAX);
		else
			d_cl = cfg.delay_samples[DELAY_AW:0];
	end
	assign rd_addr = ptr_q - d_cl[DELAY_AW-1:0];
	assign rd_val  = rd_ok_q ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		ram_we           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_GAIN_HI;
			end
			ST_GAIN_HI: begin
				mul_a   = $signed({1'b0, mag_q});
				mul_b   = $signed({13'd0, cfg.input_gain[39:20]});
				state_d = ST_GAIN_LO;
			end
			ST_GAIN_LO: begin
				mul_a   = $signed({1'b0, mag_q});
				mul_b   = $signed({13'd0, cfg.input_gain[19:0]});
				state_d = ST_GAIN_SUM;
			end
			ST_GAIN_SUM: state_d = ST_T_START;
			ST_T_START:  state_d = t_big ? ST_T_DONE : ST_T_MUL;
			ST_T_MUL: begin
				mul_a   = $signed({2'b0, term_q});
				mul_b   = $signed({6'd0, w_q});
				state_d = ST_T_DIV;
			end
			ST_T_DIV: begin
				mul_a   = $signed({6'd0, mul_p[56:30]});
				mul_b   = $signed({2'b0, recip_q30(n_q)});
				state_d = ST_T_DWAIT;
			end
			ST_T_DWAIT: state_d = (n_q == 3'd6) ? ST_T_SQ : ST_T_MUL;
			ST_T_SQ: begin
				mul_a   = $signed({2'b0, e_q});
				mul_b   = $signed({2'b0, e_q});
				state_d = ST_T_SQR;
			end
			ST_T_SQR: state_d = (sq_q == 3'd7) ? ST_T_QDIV : ST_T_SQ;
			ST_T_QDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, ONE_Q30 - e_q, 30'd0};
				div_req.divisor  = {1'b0, ONE_Q30} + {1'b0, e_q};
				state_d          = ST_T_QWAIT;
			end
			ST_T_QWAIT: begin
				if (!div_busy)
					state_d = ST_T_DONE;
			end
			ST_T_DONE: state_d = sel_q ? ST_NL_MUL : ST_T_START;
			ST_NL_MUL: begin
				mul_a   = $signed({9'd0, cfg.nl_scale});
				mul_b   = s_q;
				state_d = ST_NL_RND;
			end
			ST_NL_RND: state_d = ST_LP_M1;
			ST_LP_M1: begin
				mul_a   = 33'(cfg.lp_pole);
				mul_b   = 33'(sec_q ? lp2_out_q : lp1_q);
				state_d = ST_LP_M2;
			end
			ST_LP_M2: begin
				mul_a   = 33'(cfg.lp_zero_gain);
				mul_b   = 33'(sec_q ? lp1_q : wave_q);
				state_d = ST_LP_M3;
			end
			ST_LP_M3: begin
				mul_a   = 33'(cfg.lp_zero_gain);
				mul_b   = 33'(sec_q ? lp2_in_q : nl_prev_q);
				state_d = ST_LP_END;
			end
			ST_LP_END: state_d = sec_q ? ST_RD : ST_LP_M1;
			ST_RD:     state_d = ST_WR;
			ST_WR: begin
				ram_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_prev_q   <= '0;
			lp1_q       <= '0;
			lp2_in_q    <= '0;
			lp2_out_q   <= '0;
			ptr_q       <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_LP_END) begin
				if (sec_q) begin
					lp2_in_q  <= lp1_q;
					lp2_out_q <= lp_y;
				end else begin
					nl_prev_q <= wave_q;
					lp1_q     <= lp_y;
				end
			end
			if (ram_we) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q == '1)
					wrapped_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_neg_q <= bm_sample[31];
				mag_q   <= bm_sample[31] ? (32'd0 - bm_sample) : bm_sample;
			end
			ST_GAIN_LO: acc_q <= mul_p;
			ST_GAIN_SUM: begin
				u_q   <= u_d;
				sel_q <= 1'b0;
			end
			ST_T_START: begin
				tneg_q <= t_arg[25];
				w_q    <= {t_abs[19:0], 7'd0};
				term_q <= ONE_Q30;
				e_q    <= ONE_Q30;
				n_q    <= 3'd1;
				sq_q   <= 3'd0;
				tr_q   <= ONE_Q30;
			end
			ST_T_DWAIT: begin
				term_q <= rcp_quo;
				e_q    <= n_q[0] ? (e_q - rcp_quo) : (e_q + rcp_quo);
				n_q    <= n_q + 3'd1;
			end
			ST_T_SQR: begin
				e_q  <= sq_rnd[60:30];
				sq_q <= sq_q + 3'd1;
			end
			ST_T_QWAIT: begin
				if (!div_busy)
					tr_q <= div_quo;
			end
			ST_T_DONE: begin
				s_q   <= sel_q ? (s_q + tr_signed) : tr_signed;
				sel_q <= 1'b1;
			end
			ST_NL_RND: begin
				wave_q <= nl_rnd[61:30];
				sec_q  <= 1'b0;
			end
			ST_LP_M2: acc_q <= mul_p;
			ST_LP_M3: acc_q <= acc_q + mul_p;
			ST_LP_END: sec_q <= 1'b1;
			// entry counts as written once the pointer has passed it
			ST_RD: rd_ok_q <= wrapped_q || (rd_addr < ptr_q);
			ST_WR: res_q <= sat32(66'(rd_val) + 66'(cfg.ref_offset));
			ST_OUT: begin
				if (!out_valid_q || !out_stall)
					potential_q <= res_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign potential = potential_q;

	`HCRP_IMPLY(a_div_idle_on_start, div_req.start, !div_busy, "divider restarted while busy")
	`HCRP_NEXT(a_accept_starts, in_valid && !in_stall, state_q == ST_GAIN_HI, "accepted beat not started")
	`HCRP_NEXT(a_ptr_step, ram_we, ptr_q == $past(ptr_q) + 1'b1, "delay pointer skipped")
	`HCRP_IMPLY(a_out_from_seq, $rose(out_valid_q), $past(state_q == ST_OUT), "result beat without sequencer")
endmodule

[hw/rtl/hcrp_ram.sv]
// Generic single-write, registered-read RAM.
module hcrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/hcrp_mul.sv]
// Shared signed multiplier with registered product.
module hcrp_mul import hcrp_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

[hw/rtl/hcrp_div.sv]
// Restoring divider, one quotient bit per cycle.
module hcrp_div import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        busy,
	output logic [30:0] quo
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [30:0] low_q;
	logic [30:0] quo_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;

	assign trial = {rem_q, low_q[30]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend[61:31]};
			low_q <= req.dividend[30:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			low_q <= {low_q[29:0], 1'b0};
			quo_q <= {quo_q[29:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

[hw/rtl/hcrp_regs.sv]
// APB register file for gain, nonlinearity, lowpass, delay and offset.
module hcrp_regs import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_gain    <= 40'd3204046;
			cfg_q.nl_bias       <= 19'sd30278;
			cfg_q.nl_scale      <= 24'd457716;
			cfg_q.lp_pole       <= 32'sd1002010401;
			cfg_q.lp_zero_gain  <= 32'sd35865808;
			cfg_q.delay_samples <= 11'd1;
			cfg_q.ref_offset    <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_INPUT_GAIN:    cfg_q.input_gain    <= pwdata[39:0];
				REG_NL_BIAS:       cfg_q.nl_bias       <= pwdata[18:0];
				REG_NL_SCALE:      cfg_q.nl_scale      <= pwdata[23:0];
				REG_LP_POLE:       cfg_q.lp_pole       <= pwdata[31:0];
				REG_LP_ZERO_GAIN:  cfg_q.lp_zero_gain  <= pwdata[31:0];
				REG_DELAY_SAMPLES: cfg_q.delay_samples <= pwdata[10:0];
				REG_REF_OFFSET:    cfg_q.ref_offset    <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_INPUT_GAIN:    prdata = {24'd0, cfg_q.input_gain};
			REG_NL_BIAS:       prdata = {45'd0, cfg_q.nl_bias};
			REG_NL_SCALE:      prdata = {40'd0, cfg_q.nl_scale};
			REG_LP_POLE:       prdata = {32'd0, cfg_q.lp_pole};
			REG_LP_ZERO_GAIN:  prdata = {32'd0, cfg_q.lp_zero_gain};
			REG_DELAY_SAMPLES: prdata = {53'd0, cfg_q.delay_samples};
			REG_REF_OFFSET:    prdata = {32'd0, cfg_q.ref_offset};
			default:           prdata = '0;
		endcase
	end
endmodule
